### rtl/spsl_pkg.sv
package spsl_pkg;

    // default widths
    localparam int DUTY_BITS_DEF = 16;
    localparam int WAIT_BITS_DEF = 20;

    // width of the time registers (step period and settle time)
    localparam int TIME_BITS = 20;

    // settle time after reset, in microseconds
    localparam logic [TIME_BITS-1:0] SETTLE_RESET = TIME_BITS'(750000);

    // configuration register indexes
    localparam int CFG_ADDR_BITS = 3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_DUTY     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_DUTY     = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_TICKS   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_PERIOD  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SETTLE_TIME  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HOLD_ENABLED = 3'd5;

    // item modes
    localparam int MODE_BITS = 3;
    localparam logic [MODE_BITS-1:0] MODE_TICK     = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_MOVE_ABS = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_MOVE_REL = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_STOP     = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_PLACE    = 3'd4;

    // result events
    localparam int EVENT_BITS = 3;
    localparam logic [EVENT_BITS-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_BITS-1:0] EV_STARTED  = 3'd1;
    localparam logic [EVENT_BITS-1:0] EV_FINISHED = 3'd2;
    localparam logic [EVENT_BITS-1:0] EV_REJECTED = 3'd3;
    localparam logic [EVENT_BITS-1:0] EV_STOPPED  = 3'd4;

endpackage

### rtl/servo_pwm_slew_limiter_unit.sv
// A result is registered into the output register, or into the skid register while the output is held.
// Throughput: one item per clock while s_ready is high; all state updates in a single add and compare pass.
// Results leave through an output register backed by a one-entry skid register,
// so an item is still taken while one finished result waits at the output.
// Reset (aresetn low, synchronous) clears position, goal, flags, wait count and
// both result stages, and loads the configuration registers with their defaults.
module servo_pwm_slew_limiter_unit #(
    parameter int DUTY_BITS = spsl_pkg::DUTY_BITS_DEF,
    parameter int WAIT_BITS = spsl_pkg::WAIT_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [spsl_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [((DUTY_BITS > spsl_pkg::TIME_BITS) ?
                   DUTY_BITS : spsl_pkg::TIME_BITS)-1:0] cfg_wdata,

    // input items
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [spsl_pkg::MODE_BITS-1:0]        s_mode,
    input  logic signed [DUTY_BITS:0]             s_value,

    // result items
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [DUTY_BITS-1:0]                  m_pwm_duty,
    output logic                                  m_pwm_write,
    output logic                                  m_busy_res,
    output logic [DUTY_BITS-1:0]                  m_position,
    output logic [DUTY_BITS-1:0]                  m_goal,
    output logic [spsl_pkg::EVENT_BITS-1:0]       m_event_res,
    output logic                                  m_clamped,
    output logic                                  m_moving_up
);
    import spsl_pkg::*;

    localparam int POS_BITS = DUTY_BITS + 2;   // signed position, room for overshoot
    localparam int EXT_BITS = DUTY_BITS + 3;   // signed target before limiting

    typedef struct packed {
        logic [DUTY_BITS-1:0]  pwm_duty;
        logic                  pwm_write;
        logic                  busy;
        logic [DUTY_BITS-1:0]  position;
        logic [DUTY_BITS-1:0]  goal;
        logic [EVENT_BITS-1:0] event_code;
        logic                  clamped;
        logic                  moving_up;
    } res_t;

    // configuration registers
    logic [DUTY_BITS-1:0] min_duty_reg;
    logic [DUTY_BITS-1:0] max_duty_reg;
    logic [DUTY_BITS-1:0] step_ticks_reg;
    logic [TIME_BITS-1:0] step_period_reg;
    logic [TIME_BITS-1:0] settle_time_reg;
    logic                 hold_enabled_reg;

    // motion state
    logic signed [POS_BITS-1:0] position_reg, position_next;
    logic [DUTY_BITS-1:0]       goal_reg, goal_next;
    logic                       running_reg, running_next;
    logic                       up_reg, up_next;
    logic [WAIT_BITS-1:0]       wait_reg, wait_next;

    // result stages
    res_t out_data_reg, skid_data_reg, res_new;
    logic out_valid_reg, skid_valid_reg;

    logic accept;

    // saturate a signed position to the duty range
    function automatic logic [DUTY_BITS-1:0] sat_duty(input logic signed [POS_BITS-1:0] v);
        logic [DUTY_BITS-1:0] r;
        if (v[POS_BITS-1]) begin
            r = '0;
        end else if (v[DUTY_BITS]) begin
            r = '1;
        end else begin
            r = v[DUTY_BITS-1:0];
        end
        return r;
    endfunction

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_duty_reg     <= '0;
            max_duty_reg     <= '1;
            step_ticks_reg   <= DUTY_BITS'(1);
            step_period_reg  <= '0;
            settle_time_reg  <= SETTLE_RESET;
            hold_enabled_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MIN_DUTY:     min_duty_reg     <= cfg_wdata[DUTY_BITS-1:0];
                REG_MAX_DUTY:     max_duty_reg     <= cfg_wdata[DUTY_BITS-1:0];
                REG_STEP_TICKS:   step_ticks_reg   <= cfg_wdata[DUTY_BITS-1:0];
                REG_STEP_PERIOD:  step_period_reg  <= cfg_wdata[TIME_BITS-1:0];
                REG_SETTLE_TIME:  settle_time_reg  <= cfg_wdata[TIME_BITS-1:0];
                REG_HOLD_ENABLED: hold_enabled_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // target selection and limiting
    logic signed [EXT_BITS-1:0] val_ext, pos_ext, target_src, min_ext, max_ext, tg_cmp;
    logic [DUTY_BITS-1:0]       tg;
    logic                       tg_hit;
    logic                       tg_up;

    always_comb begin
        val_ext    = EXT_BITS'(s_value);
        pos_ext    = EXT_BITS'(position_reg);
        min_ext    = signed'({3'b000, min_duty_reg});
        max_ext    = signed'({3'b000, max_duty_reg});
        target_src = (s_mode == MODE_MOVE_REL) ? (pos_ext + val_ext) : val_ext;
        if (target_src < min_ext) begin
            tg     = min_duty_reg;
            tg_hit = 1'b1;
        end else if (target_src > max_ext) begin
            tg     = max_duty_reg;
            tg_hit = 1'b1;
        end else begin
            tg     = target_src[DUTY_BITS-1:0];
            tg_hit = 1'b0;
        end
        tg_cmp = signed'({3'b000, tg});
        tg_up  = (tg_cmp >= pos_ext);
    end

    // ramp step and end-of-move check
    logic signed [POS_BITS-1:0] goal_pos, step_ext, step_pos, tg_pos;
    logic                       ramp_done;

    always_comb begin
        goal_pos  = signed'({2'b00, goal_reg});
        tg_pos    = signed'({2'b00, tg});
        step_ext  = signed'({2'b00, step_ticks_reg});
        step_pos  = up_reg ? (position_reg + step_ext) : (position_reg - step_ext);
        ramp_done = (step_period_reg == '0) || (position_reg == goal_pos) ||
                    (up_reg && (position_reg > goal_pos)) ||
                    (!up_reg && (position_reg < goal_pos));
    end

    // next state and result for the presented item
    always_comb begin
        position_next     = position_reg;
        goal_next         = goal_reg;
        running_next      = running_reg;
        up_next           = up_reg;
        wait_next         = wait_reg;
        res_new.pwm_duty  = '0;
        res_new.pwm_write = 1'b0;
        res_new.event_code = EV_NONE;
        res_new.clamped   = 1'b0;

        case (s_mode)
            MODE_TICK: begin
                if (running_reg) begin
                    if (wait_reg > WAIT_BITS'(1)) begin
                        wait_next = wait_reg - WAIT_BITS'(1);
                    end else begin
                        wait_next = '0;
                        if (ramp_done) begin
                            position_next      = goal_pos;
                            running_next       = 1'b0;
                            res_new.pwm_write  = !hold_enabled_reg;
                            res_new.event_code = EV_FINISHED;
                        end else begin
                            position_next     = step_pos;
                            res_new.pwm_write = 1'b1;
                            res_new.pwm_duty  = sat_duty(step_pos);
                            wait_next         = WAIT_BITS'(step_period_reg);
                        end
                    end
                end
            end
            MODE_MOVE_ABS, MODE_MOVE_REL: begin
                if (running_reg) begin
                    res_new.event_code = EV_REJECTED;
                end else begin
                    res_new.clamped    = tg_hit;
                    up_next            = tg_up;
                    goal_next          = tg;
                    running_next       = 1'b1;
                    res_new.pwm_write  = 1'b1;
                    res_new.event_code = EV_STARTED;
                    if (step_period_reg != '0) begin
                        res_new.pwm_duty = sat_duty(position_reg);
                        wait_next = (tg_pos == position_reg) ?
                                    WAIT_BITS'(settle_time_reg) :
                                    WAIT_BITS'(step_period_reg);
                    end else begin
                        res_new.pwm_duty = tg;
                        wait_next        = WAIT_BITS'(settle_time_reg);
                    end
                end
            end
            MODE_STOP: begin
                if (running_reg) begin
                    running_next       = 1'b0;
                    position_next      = signed'({2'b00, sat_duty(position_reg)});
                    goal_next          = sat_duty(position_reg);
                    wait_next          = '0;
                    res_new.pwm_write  = 1'b1;
                    res_new.event_code = EV_STOPPED;
                end
            end
            MODE_PLACE: begin
                position_next      = tg_pos;
                goal_next          = tg;
                up_next            = 1'b1;
                running_next       = 1'b1;
                wait_next          = WAIT_BITS'(settle_time_reg);
                res_new.pwm_write  = 1'b1;
                res_new.pwm_duty   = tg;
                res_new.clamped    = tg_hit;
                res_new.event_code = EV_STARTED;
            end
            default: ;
        endcase

        res_new.busy      = running_next;
        res_new.position  = sat_duty(position_next);
        res_new.goal      = goal_next;
        res_new.moving_up = up_next;
    end

    // handshake
    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // motion state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            goal_reg     <= '0;
            running_reg  <= 1'b0;
            up_reg       <= 1'b0;
            wait_reg     <= '0;
        end else if (accept) begin
            position_reg <= position_next;
            goal_reg     <= goal_next;
            running_reg  <= running_next;
            up_reg       <= up_next;
            wait_reg     <= wait_next;
        end
    end

    // output register and skid stage control
    logic out_free;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (accept) begin
                out_data_reg <= res_new;
            end
        end else if (accept) begin
            skid_data_reg <= res_new;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pwm_duty  = out_data_reg.pwm_duty;
    assign m_pwm_write = out_data_reg.pwm_write;
    assign m_busy_res  = out_data_reg.busy;
    assign m_position  = out_data_reg.position;
    assign m_goal      = out_data_reg.goal;
    assign m_event_res = out_data_reg.event_code;
    assign m_clamped   = out_data_reg.clamped;
    assign m_moving_up = out_data_reg.moving_up;

    // skid entry only exists behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while output register is empty");

    // no wait pending once idle
    a_idle_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (wait_reg == '0))
        else $error("wait count nonzero while idle");

    // a refused move only happens while busy
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res == EV_REJECTED)) |-> m_busy_res)
        else $error("move rejected while not busy");

    // finished and stopped items leave the block idle
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_event_res == EV_FINISHED) || (m_event_res == EV_STOPPED)))
        |-> !m_busy_res)
        else $error("block still busy after move ended");

    // duty is zero unless the pwm is written
    a_duty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pwm_write) |-> (m_pwm_duty == '0))
        else $error("nonzero duty without pwm write");

endmodule
